/* src/signed_integer_alu_with_div_check_unit_defines.svh */
// Assertion macros shared by the checker.
`ifndef SIGNED_INTEGER_ALU_WITH_DIV_CHECK_UNIT_DEFINES_SVH
`define SIGNED_INTEGER_ALU_WITH_DIV_CHECK_UNIT_DEFINES_SVH

// Implication checked on every edge outside reset.
`define SIA_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked on the edge after the antecedent.
`define SIA_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sia_pkg.sv */
`default_nettype none
package sia_pkg;
	localparam int DataWidth = 32;
	localparam int KindWidth = 3;
	localparam int StatusWidth = 2;

	localparam logic [KindWidth-1:0] OP_ADD = 3'd0;
	localparam logic [KindWidth-1:0] OP_SUB = 3'd1;
	localparam logic [KindWidth-1:0] OP_MUL = 3'd2;
	localparam logic [KindWidth-1:0] OP_DIV = 3'd3;
	localparam logic [KindWidth-1:0] OP_REM = 3'd4;

	localparam logic [StatusWidth-1:0] ST_OK = 2'd0;
	localparam logic [StatusWidth-1:0] ST_DIV_ZERO = 2'd1;
	localparam logic [StatusWidth-1:0] ST_MOD_ZERO = 2'd2;
	localparam logic [StatusWidth-1:0] ST_INVALID = 2'd3;

	// Control that travels with an item down the pipe.
	typedef struct packed {
		logic [KindWidth-1:0] kind;
		logic neg_q;     // quotient negative
		logic neg_r;     // remainder negative
		logic b_zero;
	} sia_ctl_t;
endpackage
`default_nettype wire

/* src/sia_mul.sv */
`default_nettype none
// Low half multiply, split into three half-width products over two stages.
module sia_mul #(
	parameter int DATA_WIDTH = sia_pkg::DataWidth
) (
	input wire logic clk,
	input wire logic en_s1,
	input wire logic en_s2,
	input wire logic [DATA_WIDTH-1:0] a,
	input wire logic [DATA_WIDTH-1:0] b,
	output logic [DATA_WIDTH-1:0] prod
);
	import sia_pkg::*;
	localparam int H = DATA_WIDTH / 2;
	localparam int L = DATA_WIDTH - H;

	logic [2*L-1:0] ll_s1;
	logic [DATA_WIDTH-1:0] lh_s1, hl_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ll_s1 <= {{L{1'b0}}, a[L-1:0]} * {{L{1'b0}}, b[L-1:0]};
			lh_s1 <= DATA_WIDTH'({{H{1'b0}}, a[L-1:0]} * {{L{1'b0}}, b[DATA_WIDTH-1:L]});
			hl_s1 <= DATA_WIDTH'({{L{1'b0}}, a[DATA_WIDTH-1:L]} * {{H{1'b0}}, b[L-1:0]});
		end
		if (en_s2)
			prod <= DATA_WIDTH'(ll_s1) + ((lh_s1 + hl_s1) << L);
	end
endmodule
`default_nettype wire

/* src/sia_div.sv */
`default_nettype none
// Unsigned restoring divider, one quotient bit per stage.
module sia_div #(
	parameter int DATA_WIDTH = sia_pkg::DataWidth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic in_valid,
	input wire logic [DATA_WIDTH-1:0] num,
	input wire logic [DATA_WIDTH-1:0] den,
	input wire sia_pkg::sia_ctl_t in_ctl,
	output logic out_valid,
	output logic [DATA_WIDTH-1:0] quo,
	output logic [DATA_WIDTH-1:0] rem,
	output sia_pkg::sia_ctl_t out_ctl
);
	import sia_pkg::*;

	logic [DATA_WIDTH-1:0] n_s [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] r_s [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] d_s [DATA_WIDTH+1];
	sia_ctl_t c_s [DATA_WIDTH+1];
	logic [DATA_WIDTH:0] v_s;

	assign n_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;
	assign c_s[0] = in_ctl;
	assign v_s[0] = in_valid;

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
		logic [DATA_WIDTH:0] trial;
		logic [DATA_WIDTH:0] diff;
		assign trial = {r_s[i], n_s[i][DATA_WIDTH-1]};
		assign diff = trial - {1'b0, d_s[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else if (adv) v_s[i+1] <= v_s[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				d_s[i+1] <= d_s[i];
				c_s[i+1] <= c_s[i];
				if (diff[DATA_WIDTH]) begin
					r_s[i+1] <= trial[DATA_WIDTH-1:0];
					n_s[i+1] <= {n_s[i][DATA_WIDTH-2:0], 1'b0};
				end else begin
					r_s[i+1] <= diff[DATA_WIDTH-1:0];
					n_s[i+1] <= {n_s[i][DATA_WIDTH-2:0], 1'b1};
				end
			end
		end
	end

	assign out_valid = v_s[DATA_WIDTH];
	assign quo = n_s[DATA_WIDTH];
	assign rem = r_s[DATA_WIDTH];
	assign out_ctl = c_s[DATA_WIDTH];
endmodule
`default_nettype wire

/* src/signed_integer_alu_with_div_check_unit.sv */
// Signed integer ALU: add, subtract, multiply, divide, remainder.
// Input channel: in_valid/in_ready with kind, operand_a, operand_b.
// Output channel: out_valid/out_ready with result, status.
// Every transaction passes through one fixed pipeline of DATA_WIDTH+2
// register stages (34 at 32 bits): one operand-prep stage, one stage
// per quotient bit in the restoring divider and the output register.
// Sign fix-up and status are decoded right in front of the output register.
// All operations share this depth so results leave in order; the
// multiplier finishes early and rides along.
// Throughput: one transaction per cycle unless the output stalls, set by the per-bit divider
// stages, each of which holds an independent transaction.
// Stall: the whole pipe advances only when the output register is
// empty or being taken. in_ready is that advance condition, so a
// stalled receiver holds everything and nothing is lost or repeated.
// Reset: arst_n clears all valid bits; the pipe is empty afterwards.
// Status: 0 ok, 1 divide by zero, 2 remainder by zero, 3 bad kind;
// error cases return result 0. Overflow wraps to DATA_WIDTH bits.
`default_nettype none
module signed_integer_alu_with_div_check_unit #(
	parameter int DATA_WIDTH = sia_pkg::DataWidth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [sia_pkg::KindWidth-1:0] kind,
	input wire logic signed [DATA_WIDTH-1:0] operand_a,
	input wire logic signed [DATA_WIDTH-1:0] operand_b,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [DATA_WIDTH-1:0] result,
	output logic [sia_pkg::StatusWidth-1:0] status
);
	import sia_pkg::*;

	// Pipe advance: output slot free or being drained.
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: magnitudes, sign and zero flags.
	logic v_s1;
	logic [DATA_WIDTH-1:0] ma_s1, mb_s1;
	sia_ctl_t ctl_s1;
	logic a_neg, b_neg;
	assign a_neg = operand_a[DATA_WIDTH-1];
	assign b_neg = operand_b[DATA_WIDTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ma_s1 <= a_neg ? DATA_WIDTH'(-operand_a) : operand_a;
			mb_s1 <= b_neg ? DATA_WIDTH'(-operand_b) : operand_b;
			ctl_s1.kind <= kind;
			ctl_s1.neg_q <= a_neg ^ b_neg;
			ctl_s1.neg_r <= a_neg;
			ctl_s1.b_zero <= (operand_b == '0);
		end
	end

	// Add/sub and multiply, delayed alongside the divider.
	logic [DATA_WIDTH-1:0] prod;
	sia_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
		.clk(clk), .en_s1(adv), .en_s2(adv),
		.a(operand_a), .b(operand_b), .prod(prod)
	);

	logic [DATA_WIDTH-1:0] as_s1;
	always_ff @(posedge clk) begin
		if (adv)
			as_s1 <= (kind == OP_SUB) ? operand_a - operand_b : operand_a + operand_b;
	end

	// Delay line for the non-divide result; the product is ready one stage
	// after the sum, so it is merged in at the second tap.
	localparam int DLY = DATA_WIDTH;
	logic [DATA_WIDTH-1:0] alu_s [DLY];
	logic mul_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s2 <= (ctl_s1.kind == OP_MUL);
			alu_s[0] <= as_s1;
			alu_s[1] <= mul_s2 ? prod : alu_s[0];
			for (int i = 2; i < DLY; i++) alu_s[i] <= alu_s[i-1];
		end
	end

	logic dv;
	logic [DATA_WIDTH-1:0] quo, rem;
	sia_ctl_t dctl;
	sia_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(v_s1), .num(ma_s1), .den(mb_s1), .in_ctl(ctl_s1),
		.out_valid(dv), .quo(quo), .rem(rem), .out_ctl(dctl)
	);

	// Fix-up: sign correction and status.
	logic [DATA_WIDTH-1:0] res_c;
	logic [StatusWidth-1:0] st_c;
	always_comb begin
		res_c = '0;
		st_c = ST_OK;
		case (dctl.kind)
			OP_ADD, OP_SUB, OP_MUL: res_c = alu_s[DLY-1];
			OP_DIV: begin
				if (dctl.b_zero) st_c = ST_DIV_ZERO;
				else res_c = dctl.neg_q ? DATA_WIDTH'(-quo) : quo;
			end
			OP_REM: begin
				if (dctl.b_zero) st_c = ST_MOD_ZERO;
				else res_c = dctl.neg_r ? DATA_WIDTH'(-rem) : rem;
			end
			default: st_c = ST_INVALID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= dv;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			result <= res_c;
			status <= st_c;
		end
	end
endmodule
`default_nettype wire

/* src/sia_checker.sv */
`default_nettype none
`include "signed_integer_alu_with_div_check_unit_defines.svh"
module sia_checker #(
	parameter int DATA_WIDTH = sia_pkg::DataWidth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [DATA_WIDTH-1:0] result,
	input wire logic [sia_pkg::StatusWidth-1:0] status
);
	import sia_pkg::*;

	`SIA_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result) && $stable(status), "output changed while stalled")
	`SIA_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && status != ST_OK, result == '0, "error result not zero")
	`SIA_ASSERT_IMP(a_ready, clk, arst_n, !out_valid, in_ready, "input blocked with empty output")
	`SIA_ASSERT_IMP(a_stall, clk, arst_n, out_valid && !out_ready, !in_ready, "input taken while output stalled")
endmodule

bind signed_integer_alu_with_div_check_unit sia_checker #(.DATA_WIDTH(DATA_WIDTH)) u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .result(result), .status(status)
);
`default_nettype wire
